/* sv/fsla_pkg.sv */
package fsla_pkg;

    // Width of a slot number on the ports.
    localparam int SLOT_W = 6;

    typedef enum logic
    {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } fsla_req_t;

    typedef enum logic
    {
        ST_INIT,
        ST_RUN
    } fsla_state_t;

endpackage

/* sv/fsla_link_mem.sv */
module fsla_link_mem #(
    parameter int SLOT_COUNT = 64,
    parameter int PTR_W      = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  logic [PTR_W-1:0] wr_data,
    input  logic [PTR_W-1:0] rd_addr,
    output logic [PTR_W-1:0] rd_data
);
    import fsla_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);

    logic [PTR_W-1:0] link_mem [SLOT_COUNT];
    logic [PTR_W-1:0] rd_data_reg;
    logic             wr_in_range;
    logic             rd_in_range;

    assign wr_in_range = 32'(wr_addr) < SLOT_COUNT;
    assign rd_in_range = 32'(rd_addr) < SLOT_COUNT;

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            link_mem[wr_addr[AW-1:0]] <= wr_data;
        end
    end

    // A write to the address being read in the same cycle is forwarded, so
    // the registered word reflects the memory after this cycle; 0 past the pool.
    always_ff @(posedge clk)
    begin
        if (!rd_in_range)
        begin
            rd_data_reg <= '0;
        end
        else if (wr_en && wr_addr == rd_addr)
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= link_mem[rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/fifo_free_list_slot_allocator.sv */
// Channel   Signals                          Direction  Transfer rule
// request   start, req_type, released_slot   in         taken when start && !busy
// grant     done, granted_slot               out        one cycle, cannot be held off
//
// One request is taken every cycle when not busy. An allocate gives its grant
// word on the cycle after it is taken; a free gives no word. The rate is set
// by the link memory: the link of the current head is kept ready in the
// memory's read register, so a head update never waits on a read. After reset
// the link memory is initialized by a pass over all entries, one entry per
// cycle, with busy high. The grant side has no stall, so nothing backs up.
module fifo_free_list_slot_allocator #(
    parameter int SLOT_COUNT     = 64,
    parameter int RESERVED_SLOTS = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        req_type,
    input  logic [fsla_pkg::SLOT_W-1:0] released_slot,
    output logic                        busy,
    output logic                        done,
    output logic [fsla_pkg::SLOT_W-1:0] granted_slot
);
    import fsla_pkg::*;

    // Slot numbers are kept wide enough both for the pool and for any value
    // the request port can carry, since frees are not range checked.
    localparam int AW = $clog2(SLOT_COUNT);
    localparam int PW = (AW > SLOT_W) ? AW : SLOT_W;

    localparam logic [PW-1:0] HEAD_RST = PW'(RESERVED_SLOTS);
    localparam logic [PW-1:0] TAIL_RST = PW'(SLOT_COUNT - 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

    // Link value of an entry right after reset: a chain through the
    // non-reserved slots, ending in 0 at the last slot.
    function automatic logic [PW-1:0] init_link(input logic [AW-1:0] idx);
        logic [PW-1:0] val;
        val = '0;
        if (32'(idx) >= RESERVED_SLOTS && 32'(idx) < SLOT_COUNT - 1)
        begin
            val = PW'(32'(idx) + 1);
        end
        return val;
    endfunction

    fsla_state_t      state_reg, state_next;
    logic [AW-1:0]    init_idx_reg, init_idx_next;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic             done_reg, done_next;
    logic [SLOT_W-1:0] grant_reg, grant_next;

    logic             busy_int;
    logic             accept;
    logic [PW-1:0]    slot_ext;
    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    logic [PW-1:0]    wr_data;
    logic [PW-1:0]    head_link;

    assign slot_ext = PW'(released_slot);
    assign accept   = start && !busy_int;

    // The memory reads the link of the next head, so head_link always holds
    // the link of head_reg.
    fsla_link_mem #(
        .SLOT_COUNT(SLOT_COUNT),
        .PTR_W     (PW)
    ) u_link_mem (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(head_next),
        .rd_data(head_link)
    );

    // Next state: stay in the initialization pass until the last entry.
    always_comb
    begin
        state_next    = state_reg;
        init_idx_next = init_idx_reg;
        case (state_reg)
            ST_INIT:
            begin
                init_idx_next = init_idx_reg + AW'(1);
                if (init_idx_reg == LAST_IDX)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                init_idx_next = init_idx_reg;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        case (state_reg)
            ST_INIT: busy_int = 1'b1;
            ST_RUN:  busy_int = 1'b0;
            default: busy_int = 1'b1;
        endcase
    end

    // Request handling. An allocate pops the head; a free appends at the tail
    // by writing the old tail's link, or starts an empty list. The new tail's
    // link is not cleared: a link is only followed from a head that is not the
    // tail, and the tail's link is always rewritten before the tail moves on.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        done_next  = 1'b0;
        grant_next = grant_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        wr_data    = slot_ext;
        if (busy_int)
        begin
            wr_en   = 1'b1;
            wr_addr = PW'(init_idx_reg);
            wr_data = init_link(init_idx_reg);
        end
        else if (accept)
        begin
            if (req_type == REQ_ALLOC)
            begin
                done_next  = 1'b1;
                grant_next = head_reg[SLOT_W-1:0];
                if (head_reg == '0)
                begin
                    grant_next = '0;
                end
                else if (head_reg == tail_reg)
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else
                begin
                    head_next = head_link;
                end
            end
            else
            begin
                if (head_reg == '0)
                begin
                    head_next = slot_ext;
                    tail_next = slot_ext;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = tail_reg;
                    wr_data   = slot_ext;
                    tail_next = slot_ext;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            init_idx_reg <= '0;
            head_reg     <= HEAD_RST;
            tail_reg     <= TAIL_RST;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_idx_reg <= init_idx_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grant_reg <= grant_next;
    end

    assign busy         = busy_int;
    assign done         = done_reg;
    assign granted_slot = grant_reg;

    // A grant word appears only for an allocate taken the cycle before.
    a_done_from_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && req_type == REQ_ALLOC))
        else $error("grant word without an allocate request");

    // An allocate from an empty pool grants slot 0 and leaves the pool empty.
    a_empty_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_ALLOC && head_reg == '0)
        |=> (done && granted_slot == '0 && head_reg == '0))
        else $error("allocate from an empty pool misbehaved");

    // Popping a head that is not the last free slot follows its link.
    a_head_follows_link: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_ALLOC && head_reg != '0 && head_reg != tail_reg)
        |=> (head_reg == $past(head_link)))
        else $error("head did not advance along its link");

    // Initialization ends only after the last memory entry is written.
    a_init_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ($past(init_idx_reg) == LAST_IDX))
        else $error("link memory initialization ended early");

endmodule

/* tb/sv/fifo_free_list_slot_allocator_tb.sv */
module fifo_free_list_slot_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fsla_pkg::*;

    localparam int SLOT_COUNT     = 64;
    localparam int RESERVED_SLOTS = 2;
    localparam int WORD_TARGET    = 1650;
    // Cycles without any accepted word before the run is declared hung. The
    // slowest legitimate stretch is the link memory initialization pass after
    // reset plus the longest sender gap.
    localparam int HANG_LIMIT     = 1000;
    // A grant word comes on the cycle after its request is taken, so a drain
    // after the last expected grant is enough to catch a stray one.
    localparam int DRAIN_CYCLES   = 4;

    // One request word as the sender will present it, together with the
    // number of idle cycles the sender waits before raising start for it.
    typedef struct
    {
        fsla_req_t         kind;
        logic [SLOT_W-1:0] slot;
        int unsigned       gap;
    } slot_request_t;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    logic              req_type      = 1'b0;
    logic [SLOT_W-1:0] released_slot = '0;
    logic              busy;
    logic              done;
    logic [SLOT_W-1:0] granted_slot;

    fifo_free_list_slot_allocator #(
        .SLOT_COUNT     (SLOT_COUNT),
        .RESERVED_SLOTS (RESERVED_SLOTS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req_type      (req_type),
        .released_slot (released_slot),
        .busy          (busy),
        .done          (done),
        .granted_slot  (granted_slot)
    );

    // Requests waiting to be driven, filled up front by the stimulus block.
    slot_request_t     pending_requests[$];
    // Grants that the free list must still produce, oldest first.
    logic [SLOT_W-1:0] expected_grants[$];

    // Our own copy of the free list: head, tail and one link per slot.
    // Slot numbers are 6 bits wide and the pool has 64 entries, so every
    // link access lands inside the array.
    logic [SLOT_W-1:0] list_head;
    logic [SLOT_W-1:0] list_tail;
    logic [SLOT_W-1:0] slot_link[SLOT_COUNT];

    int unsigned       mismatch_count = 0;
    int unsigned       idle_cycles    = 0;
    int unsigned       gap_style      = 0;
    logic              word_taken     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Free list right after reset: the reserved slots are left out, every
    // other slot points to the next one and the last slot ends the chain.
    function automatic void clear_free_list();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_link[i] = (i >= RESERVED_SLOTS && i < SLOT_COUNT - 1) ? SLOT_W'(i + 1) : '0;
        end
        list_head = SLOT_W'(RESERVED_SLOTS);
        list_tail = SLOT_W'(SLOT_COUNT - 1);
    endfunction

    // Apply one accepted request to the free list and record the grant an
    // allocate is due to return.
    function automatic void advance_free_list(input fsla_req_t kind,
                                              input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] grant;
        if (kind == REQ_ALLOC)
        begin
            if (list_head == '0)
            begin
                // The pool is empty: grant 0 and leave the list alone.
                grant = '0;
            end
            else if (list_head == list_tail)
            begin
                // The last free slot goes out and the list becomes empty.
                grant     = list_head;
                list_head = '0;
                list_tail = '0;
            end
            else
            begin
                grant     = list_head;
                list_head = slot_link[list_head];
            end
            expected_grants.push_back(grant);
        end
        else if (list_head == '0)
        begin
            // A free into an empty list makes the slot both head and tail and
            // leaves its link untouched. Freeing slot 0 here keeps it empty.
            list_head = slot;
            list_tail = slot;
        end
        else
        begin
            // Nothing is checked: reserved, duplicate and zero slots are
            // simply appended at the tail.
            slot_link[list_tail] = slot;
            list_tail            = slot;
            slot_link[slot]      = '0;
        end
    endfunction

    function automatic int unsigned draw_gap();
        case (gap_style)
            0:       return 0;
            1:       return $urandom_range(0, 16);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    function automatic void queue_request(input fsla_req_t kind, input logic [SLOT_W-1:0] slot);
        slot_request_t req;
        req.kind = kind;
        req.slot = slot;
        req.gap  = draw_gap();
        pending_requests.push_back(req);
    endfunction

    // Frees mostly pick any slot, with a bias toward the corner numbers: the
    // empty marker, a reserved slot and the all-ones slot.
    function automatic logic [SLOT_W-1:0] pick_free_slot();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SLOT_W'(1);
            2:       return '1;
            default: return SLOT_W'($urandom);
        endcase
    endfunction

    // Driver. Inputs move on the falling edge only. A word stays on the
    // ports with start high until the monitor saw it accepted; then the
    // sender sits out the gap that was drawn for the next word. While start
    // is low the data ports carry junk that the block has to ignore.
    always @(negedge clk)
    begin : request_driver
        slot_request_t req;
        logic          launch;
        logic          gap_armed;
        int unsigned   gap_left;
        if (!rst_n)
        begin
            start     <= 1'b0;
            gap_armed  = 1'b0;
            gap_left   = 0;
        end
        else if (!start || word_taken)
        begin
            launch = 1'b0;
            if (pending_requests.size() != 0)
            begin
                if (!gap_armed)
                begin
                    gap_left  = pending_requests[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left == 0)
                    launch = 1'b1;
                else
                    gap_left--;
            end
            if (launch)
            begin
                req            = pending_requests.pop_front();
                gap_armed      = 1'b0;
                start         <= 1'b1;
                req_type      <= req.kind;
                released_slot <= req.slot;
            end
            else
            begin
                start         <= 1'b0;
                req_type      <= 1'($urandom);
                released_slot <= SLOT_W'($urandom);
            end
        end
    end

    // Monitor. Everything is sampled on the rising edge. A grant word is
    // checked against the oldest expectation before the request taken on
    // the same edge is fed to the free list copy.
    always @(posedge clk)
    begin : grant_monitor
        logic [SLOT_W-1:0] want;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
        end
        else
        begin
            if (done !== 1'b0)
            begin
                if (expected_grants.size() == 0)
                begin
                    report_mismatch($sformatf("grant %0d with no allocate outstanding",
                                              granted_slot));
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (done !== 1'b1 || granted_slot !== want)
                        report_mismatch($sformatf("done %b granted_slot %0d, expected %0d",
                                                  done, granted_slot, want));
                end
            end
            if (start && busy === 1'b0)
            begin
                advance_free_list(fsla_req_t'(req_type), released_slot);
                word_taken <= 1'b1;
            end
            else
            begin
                word_taken <= 1'b0;
            end
        end
    end

    // Hang detection: any accepted request or grant word resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && busy === 1'b0) || done === 1'b1)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no word accepted for %0d cycles", HANG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : stimulus
        int unsigned word_count;
        int unsigned burst;
        clear_free_list();

        // Directed opening: the first grants come straight off the reset
        // chain, then frees of the all-ones slot, slot 0 into a live list,
        // a reserved slot, an already granted slot and a slot that is still
        // on the list, with allocates in between to walk the changed links.
        gap_style = 2;
        queue_request(REQ_ALLOC, '1);
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_FREE, '1);
        queue_request(REQ_ALLOC, SLOT_W'(21));
        queue_request(REQ_FREE, '0);
        queue_request(REQ_FREE, SLOT_W'(1));
        queue_request(REQ_FREE, SLOT_W'(2));
        queue_request(REQ_ALLOC, SLOT_W'(42));
        queue_request(REQ_FREE, SLOT_W'(42));
        queue_request(REQ_FREE, SLOT_W'(21));
        queue_request(REQ_FREE, SLOT_W'(7));
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_FREE, SLOT_W'(7));
        for (int i = 0; i < 6; i++)
            queue_request(REQ_ALLOC, SLOT_W'($urandom));
        word_count = pending_requests.size();

        // Random part, built from scenarios. Drains push the list through
        // its last slot into the empty state, where allocates must return 0
        // and a free restarts the list from a single slot.
        while (word_count < WORD_TARGET)
        begin
            gap_style = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    burst = $urandom_range(5, 40);
                    for (int i = 0; i < burst; i++)
                    begin
                        if ($urandom_range(0, 99) < 55)
                            queue_request(REQ_ALLOC, SLOT_W'($urandom));
                        else
                            queue_request(REQ_FREE, pick_free_slot());
                    end
                end
                4, 5:
                begin
                    burst = $urandom_range(40, 80);
                    for (int i = 0; i < burst; i++)
                        queue_request(REQ_ALLOC, SLOT_W'($urandom));
                end
                6, 7:
                begin
                    burst = $urandom_range(1, 25);
                    for (int i = 0; i < burst; i++)
                        queue_request(REQ_FREE, pick_free_slot());
                end
                default:
                begin
                    // The list never holds more than 64 slots, so 70 allocates
                    // empty it for sure before the restart is exercised.
                    burst = 70;
                    for (int i = 0; i < burst; i++)
                        queue_request(REQ_ALLOC, SLOT_W'($urandom));
                    queue_request(REQ_FREE, pick_free_slot());
                    queue_request(REQ_ALLOC, SLOT_W'($urandom));
                    queue_request(REQ_ALLOC, SLOT_W'($urandom));
                    queue_request(REQ_FREE, pick_free_slot());
                    queue_request(REQ_FREE, pick_free_slot());
                    queue_request(REQ_ALLOC, SLOT_W'($urandom));
                    queue_request(REQ_ALLOC, SLOT_W'($urandom));
                    queue_request(REQ_ALLOC, SLOT_W'($urandom));
                    burst = burst + 8;
                end
            endcase
            word_count += burst;
        end

        // Wait for the last request to go in and its grant to come out; the
        // watchdog bounds both loops.
        while (pending_requests.size() != 0 || start)
            @(posedge clk);
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
sv/fsla_pkg.sv
sv/fsla_link_mem.sv
sv/fifo_free_list_slot_allocator.sv
tb/sv/fifo_free_list_slot_allocator_tb.sv
